[src/asfc_pkg.sv]
// Package for the audio sample format converter: format table, request and
// result structs, byte-order and bit-search helpers. No dependencies.
package asfc_pkg;

  localparam logic [1:0] KIND_INT = 2'd0;
  localparam logic [1:0] KIND_F32 = 2'd1;
  localparam logic [1:0] KIND_F64 = 2'd2;

  // register indexes of the write port
  localparam logic [1:0] REG_SAMPLE_FORMAT = 2'd0;
  localparam logic [1:0] REG_DIRECTION     = 2'd1;

  localparam logic DIR_DECODE = 1'b0;

  typedef struct packed {
    logic [1:0] kind;
    logic [3:0] nbytes;
    logic [5:0] bits;
    logic       big;
    logic       known;
  } fmt_t;

  typedef struct packed {
    logic [63:0] sample_in;
    logic        end_of_block;
  } sample_req_t;

  typedef struct packed {
    logic [63:0] sample_out;
    logic [3:0]  container_bytes;
    logic        end_of_block_out;
  } sample_res_t;

  // container format code to its description
  function automatic fmt_t fmt_lookup(input logic [4:0] code);
    fmt_t f;
    f = '{kind: KIND_INT, nbytes: 4'd0, bits: 6'd0, big: 1'b0, known: 1'b0};
    case (code)
      5'd0, 5'd1: f = '{KIND_INT, 4'd2, 6'd16, code[0], 1'b1};
      5'd2, 5'd3: f = '{KIND_INT, 4'd3, 6'd24, code[0], 1'b1};
      5'd4, 5'd5: f = '{KIND_INT, 4'd4, 6'd32, code[0], 1'b1};
      5'd6, 5'd7: f = '{KIND_F32, 4'd4, 6'd32, code[0], 1'b1};
      5'd8, 5'd9: f = '{KIND_F64, 4'd8, 6'd0, code[0], 1'b1};
      5'd10, 5'd14: f = '{KIND_INT, 4'd4, 6'd16, code[2], 1'b1};
      5'd11, 5'd15: f = '{KIND_INT, 4'd4, 6'd18, code[2], 1'b1};
      5'd12, 5'd16: f = '{KIND_INT, 4'd4, 6'd20, code[4], 1'b1};
      5'd13, 5'd17: f = '{KIND_INT, 4'd4, 6'd24, code[4], 1'b1};
      default: f = '{kind: KIND_INT, nbytes: 4'd0, bits: 6'd0, big: 1'b0, known: 1'b0};
    endcase
    return f;
  endfunction

  // keep the low n bytes
  function automatic logic [63:0] low_bytes(input logic [63:0] v, input logic [3:0] n);
    logic [63:0] r;
    case (n)
      4'd2:    r = {48'd0, v[15:0]};
      4'd3:    r = {40'd0, v[23:0]};
      4'd4:    r = {32'd0, v[31:0]};
      4'd8:    r = v;
      default: r = 64'd0;
    endcase
    return r;
  endfunction

  // reverse the low n bytes, upper bytes zero
  function automatic logic [63:0] reverse_bytes(input logic [63:0] v, input logic [3:0] n);
    logic [63:0] r;
    case (n)
      4'd2:    r = {48'd0, v[7:0], v[15:8]};
      4'd3:    r = {40'd0, v[7:0], v[15:8], v[23:16]};
      4'd4:    r = {32'd0, v[7:0], v[15:8], v[23:16], v[31:24]};
      4'd8:    r = {v[7:0], v[15:8], v[23:16], v[31:24],
                    v[39:32], v[47:40], v[55:48], v[63:56]};
      default: r = 64'd0;
    endcase
    return r;
  endfunction

  // mask of the low b bits, b up to 32
  function automatic logic [31:0] mask32(input logic [5:0] b);
    logic [32:0] m;
    m = (33'd1 << b) - 33'd1;
    return m[31:0];
  endfunction

  // position of the highest set bit
  function automatic logic [4:0] lead_one(input logic [31:0] v);
    logic [4:0] p;
    p = 5'd0;
    for (int i = 0; i < 32; i++) begin
      if (v[i]) p = 5'(i);
    end
    return p;
  endfunction

endpackage

[src/audio_sample_format_converter_top.sv]
// Top level of the audio sample format converter: registers, input and
// result stages. Depends on asfc_pkg, asfc_decode and asfc_encode.
//
// Converts one sample per request between a container format and float32.
// A request is taken whenever start is high (busy is always low), so one
// sample can enter every clock. The request is captured in the input
// register, passed through the single-pass conversion logic and captured in
// the result register, which shows it with done high for exactly one cycle;
// it cannot be held off, so the receiver must take it then. Write
// sample_format and direction only while no request is in flight.
// Undefined format codes give a zero sample and zero container_bytes.
module audio_sample_format_converter_top (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  asfc_pkg::sample_req_t req,
  output logic                  done,
  output asfc_pkg::sample_res_t res,
  input  logic                  wr_en,
  input  logic [1:0]            wr_index,
  input  logic [4:0]            wr_data
);

  logic [4:0]            sample_format;
  logic                  direction;
  logic                  req_valid;
  asfc_pkg::sample_req_t req_q;
  asfc_pkg::fmt_t        fmt;
  logic [31:0]           dec_f32;
  logic [63:0]           enc_bits;
  asfc_pkg::sample_res_t res_next;

  assign busy = 1'b0;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_format <= 5'd0;
      direction     <= 1'b0;
    end else if (wr_en) begin
      if (wr_index == asfc_pkg::REG_SAMPLE_FORMAT) sample_format <= wr_data;
      else if (wr_index == asfc_pkg::REG_DIRECTION) direction <= wr_data[0];
    end
  end

  // input stage
  always_ff @(posedge clk) begin
    if (rst) req_valid <= 1'b0;
    else     req_valid <= start;
  end

  always_ff @(posedge clk) begin
    if (start) req_q <= req;
  end

  assign fmt = asfc_pkg::fmt_lookup(sample_format);

  asfc_decode u_decode (
    .fmt    (fmt),
    .raw_in (req_q.sample_in),
    .f32    (dec_f32)
  );

  asfc_encode u_encode (
    .fmt       (fmt),
    .fb        (req_q.sample_in[31:0]),
    .container (enc_bits)
  );

  // result select
  always_comb begin
    res_next.end_of_block_out = req_q.end_of_block;
    res_next.container_bytes  = fmt.nbytes;
    if (!fmt.known)                             res_next.sample_out = 64'd0;
    else if (direction == asfc_pkg::DIR_DECODE) res_next.sample_out = {32'd0, dec_f32};
    else                                        res_next.sample_out = enc_bits;
  end

  // result stage
  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= req_valid;
  end

  always_ff @(posedge clk) begin
    if (req_valid) res <= res_next;
  end

endmodule

[src/asfc_decode.sv]
// Decode path: container bytes to float32 bits.
// Depends on asfc_pkg.
module asfc_decode (
  input  asfc_pkg::fmt_t fmt,
  input  logic [63:0]    raw_in,
  output logic [31:0]    f32
);

  logic [63:0] raw;
  logic [31:0] u;
  logic        sgn;
  logic [32:0] mag_w;
  logic [31:0] mag;
  logic [4:0]  p;
  logic [4:0]  sh;
  logic [8:0]  iexp;
  logic [31:0] kept;
  logic        rbit;
  logic        sticky;
  logic [30:0] int_mag;
  logic [31:0] int_f;
  logic        ds;
  logic [10:0] de;
  logic [51:0] dm;
  logic signed [12:0] ef;
  logic [12:0] nsh;
  logic [5:0]  shc;
  logic [127:0] wide;
  logic [30:0] nsum;
  logic [31:0] f64_f;

  // byte order
  always_comb begin
    raw = asfc_pkg::low_bytes(raw_in, fmt.nbytes);
    if (fmt.big) raw = asfc_pkg::reverse_bytes(raw, fmt.nbytes);
  end

  // integer to float, scaled by 2^-(bits-1)
  always_comb begin
    u       = raw[31:0] & asfc_pkg::mask32(fmt.bits);
    sgn     = u[5'(fmt.bits - 6'd1)];
    mag_w   = sgn ? ((33'd1 << fmt.bits) - {1'b0, u}) : {1'b0, u};
    mag     = mag_w[31:0];
    p       = asfc_pkg::lead_one(mag);
    iexp    = {4'd0, p} + 9'd128 - {3'd0, fmt.bits};
    sh      = p - 5'd23;
    kept    = mag >> sh;
    rbit    = (p > 5'd23) ? mag[5'(sh - 5'd1)] : 1'b0;
    sticky  = (p > 5'd23) ? |(mag & ((32'd1 << (sh - 5'd1)) - 32'd1)) : 1'b0;
    if (p <= 5'd23) begin
      int_mag = {iexp[7:0], 23'(mag << (5'd23 - p))};
    end else begin
      int_mag = {iexp[7:0], kept[22:0]} + 31'(rbit & (sticky | kept[0]));
    end
    int_f = (mag == 32'd0) ? 32'd0 : {sgn, int_mag};
  end

  // float64 narrowed to float32, round to nearest even
  always_comb begin
    ds   = raw[63];
    de   = raw[62:52];
    dm   = raw[51:0];
    ef   = $signed({2'b0, de}) - 13'sd896;
    nsh  = 13'd30 - 13'(ef);
    shc  = (nsh > 13'd63) ? 6'd63 : nsh[5:0];
    wide = {1'b1, dm, 75'd0} >> shc;
    nsum = 31'd0;
    if (de == 11'h7ff) begin
      if (dm != 52'd0) f64_f = {ds, 8'hff, 1'b1, 22'd0} | {9'd0, dm[51:29]};
      else             f64_f = {ds, 8'hff, 23'd0};
    end else if (de == 11'd0) begin
      f64_f = {ds, 31'd0};
    end else if (ef >= 13'sd255) begin
      f64_f = {ds, 8'hff, 23'd0};
    end else if (ef >= 13'sd1) begin
      nsum  = {ef[7:0], dm[51:29]} + 31'(dm[28] & ((|dm[27:0]) | dm[29]));
      f64_f = {ds, nsum};
    end else begin
      nsum  = {8'd0, wide[97:75]} + 31'(wide[74] & ((|wide[73:0]) | wide[75]));
      f64_f = {ds, nsum};
    end
  end

  // select by kind
  always_comb begin
    unique case (fmt.kind)
      asfc_pkg::KIND_INT: f32 = int_f;
      asfc_pkg::KIND_F32: f32 = raw[31:0];
      default:            f32 = f64_f;
    endcase
  end

endmodule

[src/asfc_encode.sv]
// Encode path: float32 bits to container bytes.
// Depends on asfc_pkg.
module asfc_encode (
  input  asfc_pkg::fmt_t fmt,
  input  logic [31:0]    fb,
  output logic [63:0]    container
);

  logic        s;
  logic [7:0]  e;
  logic [22:0] m;
  logic [7:0]  e_eff;
  logic [8:0]  t;
  logic [5:0]  tc;
  logic [63:0] sh;
  logic [31:0] r;
  logic [31:0] maxv;
  logic [31:0] vmask;
  logic [31:0] int_bits;
  logic [4:0]  p;
  logic [10:0] we;
  logic [63:0] wm;
  logic [63:0] f64_bits;
  logic [63:0] raw;

  // float to integer: clamp, scale, round, saturate
  always_comb begin
    s     = fb[31];
    e     = fb[30:23];
    m     = fb[22:0];
    e_eff = (e == 8'd0) ? 8'd1 : e;
    t     = 9'd158 - {3'd0, fmt.bits} - {1'b0, e_eff};
    tc    = (t > 9'd63) ? 6'd63 : t[5:0];
    sh    = {(e != 8'd0), m, 7'd0, 33'd0} >> tc;
    r     = {1'b0, sh[63:33]} + 32'(sh[32] & ((|sh[31:0]) | sh[33]));
    vmask = asfc_pkg::mask32(fmt.bits);
    maxv  = vmask >> 1;
    if (e == 8'hff && m != 23'd0) begin
      int_bits = 32'd0;
    end else if (e >= 8'd127) begin
      int_bits = s ? ((maxv + 32'd1) & vmask) : maxv;
    end else if (s) begin
      int_bits = (32'd0 - r) & vmask;
    end else begin
      int_bits = (r > maxv) ? maxv : r;
    end
  end

  // float32 widened to float64
  always_comb begin
    p  = asfc_pkg::lead_one({9'd0, m});
    we = {6'd0, p} + 11'd874;
    wm = {41'd0, m} << (6'd52 - {1'b0, p});
    if (e == 8'hff) begin
      if (m != 23'd0) f64_bits = {s, 11'h7ff, (m | 23'h400000), 29'd0};
      else            f64_bits = {s, 11'h7ff, 52'd0};
    end else if (e == 8'd0) begin
      if (m == 23'd0) f64_bits = {s, 63'd0};
      else            f64_bits = {s, we, wm[51:0]};
    end else begin
      f64_bits = {s, {3'd0, e} + 11'd896, m, 29'd0};
    end
  end

  // select by kind and order the bytes
  always_comb begin
    unique case (fmt.kind)
      asfc_pkg::KIND_INT: raw = {32'd0, int_bits};
      asfc_pkg::KIND_F32: raw = {32'd0, fb};
      default:            raw = f64_bits;
    endcase
    container = fmt.big ? asfc_pkg::reverse_bytes(raw, fmt.nbytes)
                        : asfc_pkg::low_bytes(raw, fmt.nbytes);
  end

endmodule

[bench/testbench.sv]
// Self-checking bench for the audio sample format converter: drives requests and
// register writes and predicts every result. Depends on asfc_pkg and the top level.
`timescale 1ns / 100ps

module testbench;
  import asfc_pkg::*;

  localparam int          CLK_HALF   = 2;
  localparam int          CYCLE_CAP  = 400000;
  localparam int          CODE_SPACE = 18;
  localparam logic [1:0]  REG_UNUSED = 2'd3;
  localparam logic [4:0]  CODE_BAD_LOW  = 5'd18;
  localparam logic [4:0]  CODE_BAD_HIGH = 5'd31;

  typedef struct {
    logic [1:0] kind;
    int         nbytes;
    int         nbits;
    logic       big;
    logic       ok;
  } layout_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  sample_req_t req = '0;
  logic done;
  sample_res_t res;
  logic wr_en = 1'b0;
  logic [1:0] wr_index = '0;
  logic [4:0] wr_data = '0;

  // shadow copy of the registers
  logic [4:0] fmt_code = '0;
  logic       encode_dir = 1'b0;

  sample_req_t pending_q[$];
  sample_res_t expected_q[$];
  int gap_left = 0;
  logic no_gaps = 1'b0;
  int errors = 0;
  int accepted = 0;
  int results_seen = 0;
  int cycles = 0;

  audio_sample_format_converter_top dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req(req),
    .done(done), .res(res), .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data)
  );

  always #(CLK_HALF) clk = ~clk;

  // container layout for a format code
  function automatic layout_t layout_of(input logic [4:0] code);
    layout_t l;
    l = '{KIND_INT, 0, 0, 1'b0, 1'b0};
    if (code < CODE_SPACE) begin
      l.ok = 1'b1;
      l.big = code[0];
      case (code)
        5'd0, 5'd1: begin l.nbytes = 2; l.nbits = 16; end
        5'd2, 5'd3: begin l.nbytes = 3; l.nbits = 24; end
        5'd4, 5'd5: begin l.nbytes = 4; l.nbits = 32; end
        5'd6, 5'd7: begin l.kind = KIND_F32; l.nbytes = 4; l.nbits = 32; end
        5'd8, 5'd9: begin l.kind = KIND_F64; l.nbytes = 8; l.nbits = 64; end
        default: begin
          l.nbytes = 4;
          l.big = (code >= 5'd14);
          case ((code - 5'd10) % 4)
            0: l.nbits = 16;
            1: l.nbits = 18;
            2: l.nbits = 20;
            default: l.nbits = 24;
          endcase
        end
      endcase
    end
    return l;
  endfunction

  function automatic logic [63:0] mask_bits(input int n);
    return (n >= 64) ? '1 : ((64'd1 << n) - 64'd1);
  endfunction

  function automatic logic [63:0] swap_order(input logic [63:0] v, input int n);
    logic [63:0] r;
    r = '0;
    for (int i = 0; i < n; i++) r[8*(n-1-i) +: 8] = v[8*i +: 8];
    return r;
  endfunction

  function automatic int top_bit(input logic [63:0] v);
    int p;
    p = 0;
    for (int i = 0; i < 64; i++) if (v[i]) p = i;
    return p;
  endfunction

  // shift right with round to nearest, ties to even
  function automatic logic [63:0] shift_rne(input logic [63:0] x, input int sh);
    logic [63:0] q, rem, half;
    if (sh <= 0) return x;
    if (sh >= 64) return '0;
    q = x >> sh;
    rem = x & ((64'd1 << sh) - 64'd1);
    half = 64'd1 << (sh - 1);
    if (rem > half || (rem == half && q[0])) q = q + 64'd1;
    return q;
  endfunction

  // float32 bits of v * 2^-s
  function automatic logic [31:0] int_to_single(input longint v, input int s);
    logic [63:0] mag, mant;
    logic sgn;
    int p;
    if (v == 0) return '0;
    sgn = (v < 0);
    mag = sgn ? 64'(-v) : 64'(v);
    p = top_bit(mag);
    if (p <= 23) mant = mag << (23 - p);
    else begin
      mant = shift_rne(mag, p - 23);
      if (mant[24]) begin
        mant = mant >> 1;
        p++;
      end
    end
    return {sgn, 8'(p - s + 127), mant[22:0]};
  endfunction

  function automatic logic [31:0] double_to_single(input logic [63:0] b);
    logic [10:0] e;
    logic [63:0] sig, r;
    logic [31:0] mag;
    int ex, sh;
    e = b[62:52];
    if (e == 11'h7ff) begin
      if (b[51:0] != 0) return {b[63], 31'h7fc00000 | 31'(b[51:29])};
      return {b[63], 31'h7f800000};
    end
    if (e == 0) return {b[63], 31'd0};
    ex = int'(e) - 1023;
    if (ex > 127) return {b[63], 31'h7f800000};
    sig = {11'd0, 1'b1, b[51:0]};
    sh = 29 + ((ex < -126) ? (-126 - ex) : 0);
    r = shift_rne(sig, sh);
    if (ex >= -126) mag = (32'(ex + 126) << 23) + r[31:0];
    else mag = r[31:0];
    return {b[63], mag[30:0]};
  endfunction

  function automatic logic [63:0] single_to_double(input logic [31:0] b);
    logic [7:0] e;
    logic [63:0] m;
    int p;
    e = b[30:23];
    m = {41'd0, b[22:0]};
    if (e == 8'hff) begin
      if (m != 0) return {b[31], 12'hfff, 51'd0} | (m << 29);
      return {b[31], 11'h7ff, 52'd0};
    end
    if (e == 0) begin
      if (m == 0) return {b[31], 63'd0};
      p = top_bit(m);
      m = m << (52 - p);
      return {b[31], 11'(p - 149 + 1023), m[51:0]};
    end
    return {b[31], 11'(int'(e) + 896), b[22:0], 29'd0};
  endfunction

  // float32 to a saturated integer of nbits, masked
  function automatic logic [63:0] single_to_int(input logic [31:0] b, input int nbits);
    logic [7:0] e;
    logic [63:0] sig, mag, maxv;
    int sh, ee;
    e = b[30:23];
    if (e == 8'hff && b[22:0] != 0) return '0;
    maxv = (64'd1 << (nbits - 1)) - 64'd1;
    if (e >= 8'd127) mag = 64'd1 << (nbits - 1);
    else begin
      sig = (e == 0) ? {41'd0, b[22:0]} : {40'd0, 1'b1, b[22:0]};
      ee = (e == 0) ? 1 : int'(e);
      sh = 150 - (nbits - 1) - ee;
      mag = (sh <= 0) ? (sig << (-sh)) : shift_rne(sig, sh);
    end
    if (!b[31] && mag > maxv) mag = maxv;
    return (b[31] ? -mag : mag) & mask_bits(nbits);
  endfunction

  function automatic sample_res_t convert_sample(input sample_req_t r);
    sample_res_t o;
    layout_t l;
    logic [63:0] raw, u;
    longint v;
    l = layout_of(fmt_code);
    o = '0;
    o.end_of_block_out = r.end_of_block;
    if (l.ok) begin
      o.container_bytes = 4'(l.nbytes);
      if (encode_dir == DIR_DECODE) begin
        raw = r.sample_in & mask_bits(8 * l.nbytes);
        if (l.big) raw = swap_order(raw, l.nbytes);
        if (l.kind == KIND_INT) begin
          u = raw & mask_bits(l.nbits);
          v = longint'(u);
          if (u[l.nbits-1]) v = v - (longint'(1) <<< l.nbits);
          o.sample_out = {32'd0, int_to_single(v, l.nbits - 1)};
        end else if (l.kind == KIND_F32) o.sample_out = {32'd0, raw[31:0]};
        else o.sample_out = {32'd0, double_to_single(raw)};
      end else begin
        if (l.kind == KIND_INT) raw = single_to_int(r.sample_in[31:0], l.nbits);
        else if (l.kind == KIND_F32) raw = {32'd0, r.sample_in[31:0]};
        else raw = single_to_double(r.sample_in[31:0]);
        o.sample_out = l.big ? swap_order(raw, l.nbytes) : (raw & mask_bits(8 * l.nbytes));
      end
    end
    return o;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  // register shadow follows the write port
  always @(posedge clk) begin
    if (!rst && wr_en) begin
      if (wr_index == REG_SAMPLE_FORMAT) fmt_code <= wr_data;
      else if (wr_index == REG_DIRECTION) encode_dir <= wr_data[0];
    end
  end

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        expected_q.push_back(convert_sample(req));
        accepted++;
      end
      if (!start || !busy) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          start <= 1'b0;
        end else if (pending_q.size() > 0) begin
          req <= pending_q.pop_front();
          start <= 1'b1;
          gap_left <= pick_gap();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    sample_res_t want;
    if (!rst && done) begin
      results_seen++;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result %h", $time, res);
      end else begin
        want = expected_q.pop_front();
        if (res.sample_out !== want.sample_out) begin
          errors++;
          $display("%0t: sample_out expected %h actual %h", $time,
                   want.sample_out, res.sample_out);
        end
        if (res.container_bytes !== want.container_bytes) begin
          errors++;
          $display("%0t: container_bytes expected %0d actual %0d", $time,
                   want.container_bytes, res.container_bytes);
        end
        if (res.end_of_block_out !== want.end_of_block_out) begin
          errors++;
          $display("%0t: end_of_block_out expected %b actual %b", $time,
                   want.end_of_block_out, res.end_of_block_out);
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [4:0] val);
    @(posedge clk);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= val;
    @(posedge clk);
    wr_en <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_q.size() > 0 || start || expected_q.size() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [63:0] random_word();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] random_container(input layout_t l);
    logic [63:0] w;
    int r;
    w = random_word();
    r = $urandom_range(0, 99);
    if (l.kind == KIND_F64 && r < 60) begin
      // doubles around the float32 range, including its edges
      w[62:52] = 11'(1023 + $urandom_range(0, 320) - 180);
      if (l.big) w = swap_order(w, 8);
    end else if (l.kind == KIND_INT && r < 20) begin
      // values near zero
      w = (w[0] ? 64'd0 : '1) ^ (w & 64'hff);
      if (l.big) w = swap_order(w, l.nbytes);
    end
    return w;
  endfunction

  function automatic logic [63:0] random_float();
    logic [63:0] w;
    int r;
    w = random_word();
    r = $urandom_range(0, 99);
    if (r < 60) w[30:23] = 8'($urandom_range(90, 130));
    else if (r < 70) w[30:23] = 8'($urandom_range(0, 5));
    return w;
  endfunction

  initial begin
    logic [63:0] decode_edges[$];
    logic [63:0] encode_edges[$];
    logic [4:0] codes[$];
    layout_t l;
    sample_req_t item;

    decode_edges = '{64'h0, '1, 64'h8000, 64'h7fff, 64'h80, 64'h800000, 64'h7fffff,
                     64'h80000000, 64'h7fffffff, 64'h20000, 64'h80000, 64'hffffff01,
                     64'h7ff0000000000001, 64'hfff0000000000000, 64'h7fefffffffffffff,
                     64'h0000000000000001, 64'h36a0000000000000, 64'h47efffffefffffff};
    encode_edges = '{64'h0, 64'h80000000, 64'h3f800000, 64'hbf800000, 64'h7fc00000,
                     64'hffc00001, 64'h7f800000, 64'hff800000, 64'h40000000,
                     64'hc0000000, 64'h38400000, 64'h38a00000, 64'h00000001,
                     64'h3f7fffff, 64'hbf7fffff, 64'hffffffff3f000000};
    for (int c = 0; c < CODE_SPACE; c++) codes.push_back(5'(c));
    codes.push_back(CODE_BAD_LOW);
    codes.push_back(CODE_BAD_HIGH);

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    // a write to an unused index must leave the registers alone
    write_reg(REG_UNUSED, '1);

    for (int d = 0; d < 2; d++) begin
      foreach (codes[k]) begin
        wait_drained();
        write_reg(REG_SAMPLE_FORMAT, codes[k]);
        write_reg(REG_DIRECTION, 5'(d));
        no_gaps = ($urandom_range(0, 3) == 0);
        l = layout_of(codes[k]);
        if (d == 0) foreach (decode_edges[i]) begin
          item.sample_in = decode_edges[i];
          item.end_of_block = i[0];
          pending_q.push_back(item);
        end else foreach (encode_edges[i]) begin
          item.sample_in = encode_edges[i];
          item.end_of_block = i[0];
          pending_q.push_back(item);
        end
        for (int i = 0; i < 32; i++) begin
          item.sample_in = (d == 0) ? random_container(l) : random_float();
          item.end_of_block = ($urandom_range(0, 7) == 0);
          pending_q.push_back(item);
        end
      end
    end

    wait_drained();
    repeat (10) @(posedge clk);
    $display("covered %0d requests and %0d results over all formats, both directions",
             accepted, results_seen);
    $display("including undefined format codes and an unused register index");
    if (errors == 0 && expected_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
